// File: rtl/srb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srb_pkg: serial register block shared definitions
// Register window layout, register bit positions, action and mode codes,
// the item, result and bank write types, and the bank index helpers.
// ----------------------------------------------------------------------------
package srb_pkg;

   // register window geometry
   localparam int WINDOW_BYTES = 4096;
   localparam int WORDS        = WINDOW_BYTES / 4;
   localparam int WORD_AW      = $clog2(WORDS);
   localparam int BANK_DEPTH   = WORDS / 2;
   localparam int BANK_AW      = $clog2(BANK_DEPTH);
   localparam int OFF_W        = $clog2(WINDOW_BYTES);

   typedef logic [OFF_W-1:0]   offset_type;
   typedef logic [WORD_AW-1:0] word_addr_type;
   typedef logic [BANK_AW-1:0] bank_addr_type;

   // action codes
   localparam logic [1:0] ACT_READ   = 2'd0;
   localparam logic [1:0] ACT_WRITE  = 2'd1;
   localparam logic [1:0] ACT_POLL   = 2'd2;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   // personality codes from the select word
   localparam logic [2:0] MODE_UART = 3'd1;
   localparam logic [2:0] MODE_SPI  = 3'd2;
   localparam logic [2:0] MODE_I2C  = 3'd3;

   // byte offsets of the special registers
   localparam offset_type OFF_SEL    = 12'hFF8;
   localparam offset_type OFF_U_STAT = 12'h014;
   localparam offset_type OFF_U_CTRL = 12'h018;
   localparam offset_type OFF_U_DATA = 12'h01C;
   localparam offset_type OFF_S_CR   = 12'h010;
   localparam offset_type OFF_S_SR   = 12'h014;
   localparam offset_type OFF_S_TCR  = 12'h060;
   localparam offset_type OFF_S_TDR  = 12'h064;
   localparam offset_type OFF_S_RDR  = 12'h074;

   // words that live in flops instead of the banks
   localparam word_addr_type W_SEL  = OFF_SEL[OFF_W-1:2];
   localparam word_addr_type W_CR   = OFF_S_CR[OFF_W-1:2];
   localparam word_addr_type W_ST   = OFF_U_STAT[OFF_W-1:2];
   localparam word_addr_type W_CTRL = OFF_U_CTRL[OFF_W-1:2];
   localparam word_addr_type W_TCR  = OFF_S_TCR[OFF_W-1:2];

   localparam logic [31:0] SEL_RESET = 32'h0010_3070;

   // uart register bits
   localparam int U_TE_BIT   = 19;
   localparam int U_IDLE_BIT = 20;
   localparam int U_RDRF_BIT = 21;
   localparam int U_TC_BIT   = 22;
   localparam int U_TDRE_BIT = 23;

   // spi register bits
   localparam int S_MEN_BIT   = 0;
   localparam int S_RRF_BIT   = 9;
   localparam int S_TDF_BIT   = 0;
   localparam int S_RDF_BIT   = 1;
   localparam int S_TCF_BIT   = 10;
   localparam int S_TXMSK_BIT = 18;
   localparam int S_RXMSK_BIT = 19;
   localparam int S_CONT_BIT  = 21;

   localparam logic [31:0] U_TX_DONE    = (32'h1 << U_TDRE_BIT) | (32'h1 << U_TC_BIT);
   localparam logic [31:0] U_STAT_START = U_TX_DONE | (32'h1 << U_IDLE_BIT);
   localparam logic [31:0] S_SR_START   = 32'h1 << S_TDF_BIT;

   // one request beat
   typedef struct packed {
      logic [1:0]  action;
      offset_type  offset;
      logic [2:0]  nbytes;
      logic [31:0] write_data;
      logic        clock_ok;
      logic        peek;
      logic [7:0]  spi_in_byte;
      logic        uart_rx_avail;
      logic [7:0]  uart_rx_byte;
      logic        uart_tx_empty;
      logic        uart_poll_event;
   } item_type;

   // one response beat
   typedef struct packed {
      logic        ok;
      logic [31:0] read_data;
      logic        uart_rx_pop;
      logic        uart_tx_valid;
      logic [7:0]  uart_tx_byte;
      logic        spi_xfer_valid;
      logic [7:0]  spi_out_byte;
      logic        spi_end;
   } rsp_type;

   // bank write command
   typedef struct packed {
      logic          en;
      bank_addr_type addr;
      logic [31:0]   data;
   } bank_wr_type;

   // an access touches word w and possibly w+1: one lands in each bank
   function automatic bank_addr_type even_index(offset_type off);
      word_addr_type w1;
      w1 = off[OFF_W-1:2] + word_addr_type'(1);
      return w1[WORD_AW-1:1];
   endfunction

   function automatic bank_addr_type odd_index(offset_type off);
      return off[OFF_W-1:WORD_AW-BANK_AW+2];
   endfunction

   function automatic logic is_flop_word(word_addr_type w);
      return (w == W_SEL) || (w == W_CR) || (w == W_ST) || (w == W_CTRL) || (w == W_TCR);
   endfunction

endpackage
`default_nettype wire

// File: rtl/srb_bank.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srb_bank: one bank of the register word store
// Single write port and one registered read port; a read taken in the same
// cycle as a write to the same entry sees the new data through a bypass.
// ----------------------------------------------------------------------------
module srb_bank (
   input  wire logic                   clock,
   input  wire logic                   rd_en,
   input  wire srb_pkg::bank_addr_type rd_addr,
   input  wire srb_pkg::bank_wr_type   wr,
   output logic [31:0]                 rd_data
);
   import srb_pkg::*;

   logic [31:0]   mem_ff [BANK_DEPTH];
   logic [31:0]   q_ff;
   bank_addr_type rd_addr_ff;
   bank_addr_type last_addr_ff;
   logic [31:0]   last_data_ff;

   // storage array
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         q_ff <= mem_ff[rd_addr];
      end
   end

   // last write is always what the array holds at that entry
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_addr_ff <= rd_addr;
      end
      if (wr.en) begin
         last_addr_ff <= wr.addr;
         last_data_ff <= wr.data;
      end
   end

   assign rd_data = (rd_addr_ff == last_addr_ff) ? last_data_ff : q_ff;

endmodule
`default_nettype wire

// File: rtl/srb_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srb_core: access checks, mode behavior and control registers
// Holds the select, control and status words in flops, decides one beat per
// cycle in which fire is high and produces the response and the bank write-back.
// ----------------------------------------------------------------------------
module srb_core (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 fire,
   input  wire srb_pkg::item_type    item,
   input  wire logic [31:0]          even_rd,
   input  wire logic [31:0]          odd_rd,
   output srb_pkg::rsp_type          result,
   output srb_pkg::bank_wr_type      even_wr,
   output srb_pkg::bank_wr_type      odd_wr
);
   import srb_pkg::*;

   logic [31:0] sel_ff, cr_ff, st_ff, ctrl_ff, tcr_ff;
   logic [31:0] sel_in, cr_in, st_in, ctrl_in, tcr_in;
   logic [7:0]  held_byte_ff, held_byte_in;
   logic        held_valid_ff, held_valid_in;
   logic        started_ff, started_in;

   logic [2:0]    mode;
   word_addr_type w0, w1;
   logic [3:0]    span_sum;
   logic          span;
   logic [12:0]   end_addr;
   logic          bus_ok;
   logic          sz4;
   logic          sel_hit;
   logic [31:0]   bank_lo, bank_hi, lo, hi;
   logic [31:0]   size_mask;
   logic [4:0]    shamt;
   logic [63:0]   pair, load_pair, mask64, data64, new_pair;
   logic [31:0]   load_val, new_lo, new_hi;
   logic          plain_wr;
   logic          spi_refresh;
   logic [7:0]    spi_got;
   rsp_type       res;

   // access geometry
   assign mode     = sel_ff[2:0];
   assign w0       = item.offset[OFF_W-1:2];
   assign w1       = w0 + word_addr_type'(1);
   assign span_sum = 4'(item.offset[1:0]) + 4'(item.nbytes);
   assign span     = span_sum > 4'd4;
   assign end_addr = 13'(item.offset) + 13'(item.nbytes);
   assign sz4      = item.nbytes == 3'd4;
   assign sel_hit  = (item.offset == OFF_SEL) && sz4;
   assign bus_ok   = (item.nbytes != 3'd0) && (item.nbytes <= 3'd4) && item.clock_ok &&
                     (end_addr <= 13'(WINDOW_BYTES));

   // words of the pair, from flops or banks
   assign bank_lo = w0[0] ? odd_rd : even_rd;
   assign bank_hi = w0[0] ? even_rd : odd_rd;

   always_comb begin
      case (w0)
         W_SEL:   lo = sel_ff;
         W_CR:    lo = cr_ff;
         W_ST:    lo = st_ff;
         W_CTRL:  lo = ctrl_ff;
         W_TCR:   lo = tcr_ff;
         default: lo = bank_lo;
      endcase
   end

   always_comb begin
      case (w1)
         W_SEL:   hi = sel_ff;
         W_CR:    hi = cr_ff;
         W_ST:    hi = st_ff;
         W_CTRL:  hi = ctrl_ff;
         W_TCR:   hi = tcr_ff;
         default: hi = bank_hi;
      endcase
   end

   // byte lane load and merge
   always_comb begin
      case (item.nbytes)
         3'd1:    size_mask = 32'h0000_00FF;
         3'd2:    size_mask = 32'h0000_FFFF;
         3'd3:    size_mask = 32'h00FF_FFFF;
         default: size_mask = 32'hFFFF_FFFF;
      endcase
   end

   assign shamt     = {item.offset[1:0], 3'b000};
   assign pair      = {hi, lo};
   assign load_pair = pair >> shamt;
   assign load_val  = load_pair[31:0] & size_mask;
   assign mask64    = {32'h0, size_mask} << shamt;
   assign data64    = {32'h0, item.write_data & size_mask} << shamt;
   assign new_pair  = (pair & ~mask64) | data64;
   assign new_lo    = new_pair[31:0];
   assign new_hi    = new_pair[63:32];

   // beat decision and next state
   always_comb begin
      sel_in        = sel_ff;
      cr_in         = cr_ff;
      st_in         = st_ff;
      ctrl_in       = ctrl_ff;
      tcr_in        = tcr_ff;
      held_byte_in  = held_byte_ff;
      held_valid_in = held_valid_ff;
      started_in    = started_ff;
      res           = '0;
      plain_wr      = 1'b0;
      spi_refresh   = 1'b0;
      spi_got       = 8'hFF;
      case (item.action)
         ACT_POLL: begin
            res.ok = 1'b1;
            if (mode == MODE_UART) begin
               if (item.uart_poll_event) begin
                  if (item.uart_tx_empty) st_in = st_in | U_TX_DONE;
                  if (item.uart_rx_avail) st_in[U_RDRF_BIT] = 1'b1;
               end
            end else if (mode == MODE_SPI) begin
               st_in[S_TDF_BIT] = 1'b1;
               if (held_valid_ff) st_in[S_RDF_BIT] = 1'b1;
            end
         end
         ACT_READ: if (bus_ok) begin
            res.ok = 1'b1;
            if (sel_hit) begin
               res.read_data = sel_ff;
            end else if (mode == MODE_UART && item.offset == OFF_U_DATA && sz4) begin
               if (item.uart_rx_avail) begin
                  res.read_data   = 32'(item.uart_rx_byte);
                  res.uart_rx_pop = !item.peek;
               end
               if (!item.peek) st_in[U_RDRF_BIT] = 1'b0;
            end else if (mode == MODE_SPI && item.offset == OFF_S_RDR && sz4) begin
               if (held_valid_ff) res.read_data = 32'(held_byte_ff);
               if (!item.peek) begin
                  held_valid_in    = 1'b0;
                  st_in[S_RDF_BIT] = 1'b0;
               end
            end else if (mode == MODE_I2C) begin
               res.read_data = '0;
            end else begin
               res.read_data = load_val;
            end
         end
         ACT_WRITE: if (bus_ok) begin
            res.ok = 1'b1;
            if (sel_hit) begin
               // the first entry into uart or spi after reset sets up its status word
               sel_in = item.write_data;
               if (mode != item.write_data[2:0] && !started_ff) begin
                  if (item.write_data[2:0] == MODE_UART) begin
                     st_in      = U_STAT_START;
                     started_in = 1'b1;
                  end else if (item.write_data[2:0] == MODE_SPI) begin
                     st_in      = S_SR_START;
                     started_in = 1'b1;
                  end
               end
            end else if (mode == MODE_UART) begin
               if (item.offset == OFF_U_DATA && sz4) begin
                  if (ctrl_ff[U_TE_BIT]) begin
                     res.uart_tx_valid = 1'b1;
                     res.uart_tx_byte  = item.write_data[7:0];
                     st_in             = st_in | U_TX_DONE;
                  end
               end else begin
                  plain_wr = 1'b1;
               end
            end else if (mode == MODE_SPI) begin
               spi_refresh = 1'b1;
               if (item.offset == OFF_S_CR && sz4) begin
                  cr_in = item.write_data;
                  if (item.write_data[S_RRF_BIT]) begin
                     held_valid_in    = 1'b0;
                     st_in[S_RDF_BIT] = 1'b0;
                  end
                  if (!item.write_data[S_MEN_BIT]) res.spi_end = 1'b1;
               end else if (item.offset == OFF_S_TDR && sz4) begin
                  // one byte exchange, masks decide what goes out and what is kept
                  if (cr_ff[S_MEN_BIT]) begin
                     if (!tcr_ff[S_TXMSK_BIT]) begin
                        spi_got            = item.spi_in_byte;
                        res.spi_xfer_valid = 1'b1;
                        res.spi_out_byte   = item.write_data[7:0];
                     end
                     if (!tcr_ff[S_RXMSK_BIT]) begin
                        held_byte_in     = spi_got;
                        held_valid_in    = 1'b1;
                        st_in[S_RDF_BIT] = 1'b1;
                     end
                     st_in[S_TCF_BIT] = 1'b1;
                     if (!tcr_ff[S_CONT_BIT]) res.spi_end = 1'b1;
                  end
               end else begin
                  plain_wr = 1'b1;
               end
            end else begin
               plain_wr = 1'b1;
            end
         end
         default: res.ok = 1'b0;
      endcase

      // plain byte store into flop-backed words
      if (plain_wr) begin
         if (w0 == W_SEL)  sel_in  = new_lo;
         if (w0 == W_CR)   cr_in   = new_lo;
         if (w0 == W_ST)   st_in   = new_lo;
         if (w0 == W_CTRL) ctrl_in = new_lo;
         if (w0 == W_TCR)  tcr_in  = new_lo;
         if (span) begin
            if (w1 == W_SEL)  sel_in  = new_hi;
            if (w1 == W_CR)   cr_in   = new_hi;
            if (w1 == W_ST)   st_in   = new_hi;
            if (w1 == W_CTRL) ctrl_in = new_hi;
            if (w1 == W_TCR)  tcr_in  = new_hi;
         end
      end

      // spi status refresh after every spi-mode write other than to the select word
      if (spi_refresh) begin
         st_in[S_TDF_BIT] = 1'b1;
         if (held_valid_in) st_in[S_RDF_BIT] = 1'b1;
      end
   end

   assign result = res;

   // bank write-back
   always_comb begin
      even_wr.addr = even_index(item.offset);
      odd_wr.addr  = odd_index(item.offset);
      if (w0[0]) begin
         even_wr.en   = fire && plain_wr && span && !is_flop_word(w1);
         even_wr.data = new_hi;
         odd_wr.en    = fire && plain_wr && !is_flop_word(w0);
         odd_wr.data  = new_lo;
      end else begin
         even_wr.en   = fire && plain_wr && !is_flop_word(w0);
         even_wr.data = new_lo;
         odd_wr.en    = fire && plain_wr && span && !is_flop_word(w1);
         odd_wr.data  = new_hi;
      end
   end

   // control and status registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff        <= SEL_RESET;
         cr_ff         <= '0;
         st_ff         <= '0;
         ctrl_ff       <= '0;
         tcr_ff        <= '0;
         held_byte_ff  <= '0;
         held_valid_ff <= 1'b0;
         started_ff    <= 1'b0;
      end else if (fire) begin
         sel_ff        <= sel_in;
         cr_ff         <= cr_in;
         st_ff         <= st_in;
         ctrl_ff       <= ctrl_in;
         tcr_ff        <= tcr_in;
         held_byte_ff  <= held_byte_in;
         held_valid_ff <= held_valid_in;
         started_ff    <= started_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/multiprotocol_serial_register_block.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multiprotocol_serial_register_block: serial register window, top level
// 4 KiB byte-addressed register window with none, UART, SPI or I2C personality.
// ----------------------------------------------------------------------------
// One request beat is taken per clock while req_ready is high. While responses
// are taken at once the sustained rate is one beat per cycle, set by the single
// read-modify-write of the word store, split into an even and an odd bank so
// that an unaligned access spanning two words is still one beat. A response left
// waiting holds the next request in the input register, so input stalls only
// while the output is full and not taken, or while the store is being cleared.
// After reset a pass clears all 512 entries of each bank, one entry of each bank
// per cycle, during which req_ready stays low.
module multiprotocol_serial_register_block (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_action,
   input  wire logic [11:0] req_offset,
   input  wire logic [2:0]  req_nbytes,
   input  wire logic [31:0] req_write_data,
   input  wire logic        req_clock_ok,
   input  wire logic        req_peek,
   input  wire logic [7:0]  req_spi_in_byte,
   input  wire logic        req_uart_rx_avail,
   input  wire logic [7:0]  req_uart_rx_byte,
   input  wire logic        req_uart_tx_empty,
   input  wire logic        req_uart_poll_event,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_ok,
   output logic [31:0]      rsp_read_data,
   output logic             rsp_uart_rx_pop,
   output logic             rsp_uart_tx_valid,
   output logic [7:0]       rsp_uart_tx_byte,
   output logic             rsp_spi_xfer_valid,
   output logic [7:0]       rsp_spi_out_byte,
   output logic             rsp_spi_end
);
   import srb_pkg::*;

   item_type      req_item;
   item_type      item_ff;
   logic          s1_valid_ff;
   rsp_type       out_ff;
   logic          out_valid_ff;
   rsp_type       core_res;
   logic          fire;
   logic          req_accept;
   bank_addr_type clr_idx_ff;
   logic          clearing_ff;
   bank_wr_type   clr_wr;
   bank_wr_type   core_even_wr, core_odd_wr;
   bank_wr_type   even_wr, odd_wr;
   logic [31:0]   even_rd, odd_rd;

   // request beat gathering
   assign req_item.action          = req_action;
   assign req_item.offset          = req_offset;
   assign req_item.nbytes          = req_nbytes;
   assign req_item.write_data      = req_write_data;
   assign req_item.clock_ok        = req_clock_ok;
   assign req_item.peek            = req_peek;
   assign req_item.spi_in_byte     = req_spi_in_byte;
   assign req_item.uart_rx_avail   = req_uart_rx_avail;
   assign req_item.uart_rx_byte    = req_uart_rx_byte;
   assign req_item.uart_tx_empty   = req_uart_tx_empty;
   assign req_item.uart_poll_event = req_uart_poll_event;

   // handshake
   assign fire       = s1_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !clearing_ff && (!s1_valid_ff || fire);
   assign req_accept = req_valid && req_ready;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (fire) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= req_item;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         out_ff <= core_res;
      end
   end

   // store clearing pass after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_idx_ff  <= '0;
         clearing_ff <= 1'b1;
      end else if (clearing_ff) begin
         clr_idx_ff <= clr_idx_ff + bank_addr_type'(1);
         if (clr_idx_ff == '1) begin
            clearing_ff <= 1'b0;
         end
      end
   end

   assign clr_wr.en   = 1'b1;
   assign clr_wr.addr = clr_idx_ff;
   assign clr_wr.data = '0;

   assign even_wr = clearing_ff ? clr_wr : core_even_wr;
   assign odd_wr  = clearing_ff ? clr_wr : core_odd_wr;

   // word store banks
   srb_bank u_even_bank (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (even_index(req_offset)),
      .wr      (even_wr),
      .rd_data (even_rd)
   );

   srb_bank u_odd_bank (
      .clock   (clock),
      .rd_en   (req_accept),
      .rd_addr (odd_index(req_offset)),
      .wr      (odd_wr),
      .rd_data (odd_rd)
   );

   // beat execution
   srb_core u_core (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .item    (item_ff),
      .even_rd (even_rd),
      .odd_rd  (odd_rd),
      .result  (core_res),
      .even_wr (core_even_wr),
      .odd_wr  (core_odd_wr)
   );

   // response ports
   assign rsp_valid          = out_valid_ff;
   assign rsp_ok             = out_ff.ok;
   assign rsp_read_data      = out_ff.read_data;
   assign rsp_uart_rx_pop    = out_ff.uart_rx_pop;
   assign rsp_uart_tx_valid  = out_ff.uart_tx_valid;
   assign rsp_uart_tx_byte   = out_ff.uart_tx_byte;
   assign rsp_spi_xfer_valid = out_ff.spi_xfer_valid;
   assign rsp_spi_out_byte   = out_ff.spi_out_byte;
   assign rsp_spi_end        = out_ff.spi_end;

`ifndef NO_ASSERTIONS
   a_clear_blocks_beats: assert property (@(posedge clock) disable iff (reset)
      clearing_ff |-> !s1_valid_ff && !req_ready)
      else $error("beat in flight during store clearing");

   a_clear_once: assert property (@(posedge clock) disable iff (reset)
      !clearing_ff |=> !clearing_ff)
      else $error("store clearing restarted without reset");

   a_reject_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_read_data == 32'h0 && !rsp_uart_rx_pop &&
                               !rsp_uart_tx_valid && !rsp_spi_xfer_valid && !rsp_spi_end)
      else $error("rejected beat has side effects");

   a_one_side_channel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_uart_tx_valid && rsp_spi_xfer_valid))
      else $error("uart and spi activity in one beat");

   a_no_core_write_idle: assert property (@(posedge clock) disable iff (reset)
      !fire |-> !core_even_wr.en && !core_odd_wr.en)
      else $error("store written without a beat");
`endif

endmodule
`default_nettype wire

// File: tb/multiprotocol_serial_register_block_tb.sv
`default_nettype none
// ----------------------------------------------------------------------------
// multiprotocol_serial_register_block_tb: register window self-checking bench
// Drives read, write and poll beats through the window, predicts every
// response from a shadow copy of the word store and the spi receive holding
// byte, and compares each response field by field in arrival order.
// ----------------------------------------------------------------------------
module multiprotocol_serial_register_block_tb;
   import srb_pkg::*;

   localparam logic [2:0] MODE_NONE     = 3'd0;
   localparam logic [2:0] MODE_SPARE_LO = 3'd4;
   localparam int         STALL_LIMIT   = 4000;
   localparam int         HOLD_CYCLES   = 300;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = ACT_READ;
   logic [11:0] req_offset = '0;
   logic [2:0]  req_nbytes = '0;
   logic [31:0] req_write_data = '0;
   logic        req_clock_ok = 1'b0;
   logic        req_peek = 1'b0;
   logic [7:0]  req_spi_in_byte = '0;
   logic        req_uart_rx_avail = 1'b0;
   logic [7:0]  req_uart_rx_byte = '0;
   logic        req_uart_tx_empty = 1'b0;
   logic        req_uart_poll_event = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_ok;
   logic [31:0] rsp_read_data;
   logic        rsp_uart_rx_pop;
   logic        rsp_uart_tx_valid;
   logic [7:0]  rsp_uart_tx_byte;
   logic        rsp_spi_xfer_valid;
   logic [7:0]  rsp_spi_out_byte;
   logic        rsp_spi_end;

   // shadow state of the window
   logic [31:0] window_shadow [0:WORDS-1];
   logic [7:0]  shadow_held_byte;
   logic        shadow_held_valid;
   logic        shadow_mode_started;

   rsp_type     window_rsp_q [$];
   int unsigned accepted_items = 0;
   int unsigned rsp_count = 0;
   int unsigned mismatch_count = 0;
   int unsigned stall_cycles = 0;
   bit          no_idle = 1'b0;
   bit          hold_off_req = 1'b0;

   multiprotocol_serial_register_block dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_action          (req_action),
      .req_offset          (req_offset),
      .req_nbytes          (req_nbytes),
      .req_write_data      (req_write_data),
      .req_clock_ok        (req_clock_ok),
      .req_peek            (req_peek),
      .req_spi_in_byte     (req_spi_in_byte),
      .req_uart_rx_avail   (req_uart_rx_avail),
      .req_uart_rx_byte    (req_uart_rx_byte),
      .req_uart_tx_empty   (req_uart_tx_empty),
      .req_uart_poll_event (req_uart_poll_event),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_ok              (rsp_ok),
      .rsp_read_data       (rsp_read_data),
      .rsp_uart_rx_pop     (rsp_uart_rx_pop),
      .rsp_uart_tx_valid   (rsp_uart_tx_valid),
      .rsp_uart_tx_byte    (rsp_uart_tx_byte),
      .rsp_spi_xfer_valid  (rsp_spi_xfer_valid),
      .rsp_spi_out_byte    (rsp_spi_out_byte),
      .rsp_spi_end         (rsp_spi_end)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // response prediction
   // ------------------------------------------------------------------------

   function automatic word_addr_type word_of(offset_type off);
      return off[OFF_W-1:2];
   endfunction

   function automatic void clear_shadow();
      for (int i = 0; i < WORDS; i++) window_shadow[i] = '0;
      window_shadow[W_SEL] = SEL_RESET;
      shadow_held_byte    = '0;
      shadow_held_valid   = 1'b0;
      shadow_mode_started = 1'b0;
   endfunction

   // spi status always shows tx empty, and rx full while a byte is held
   function automatic void refresh_spi_status();
      window_shadow[word_of(OFF_S_SR)][S_TDF_BIT] = 1'b1;
      if (shadow_held_valid) window_shadow[word_of(OFF_S_SR)][S_RDF_BIT] = 1'b1;
   endfunction

   function automatic rsp_type predict_window_access(item_type it);
      rsp_type       r;
      logic [2:0]    mode;
      logic [2:0]    next_mode;
      logic [31:0]   tcr;
      logic [7:0]    got;
      offset_type    a;
      word_addr_type sr;
      logic          quad;
      r    = '0;
      sr   = word_of(OFF_S_SR);
      mode = window_shadow[W_SEL][2:0];
      quad = (it.nbytes == 3'd4);

      // poll tick skips every check
      if (it.action == ACT_POLL) begin
         if (mode == MODE_UART && it.uart_poll_event) begin
            if (it.uart_tx_empty) window_shadow[W_ST] |= U_TX_DONE;
            if (it.uart_rx_avail) window_shadow[W_ST][U_RDRF_BIT] = 1'b1;
         end else if (mode == MODE_SPI) begin
            refresh_spi_status();
         end
         r.ok = 1'b1;
         return r;
      end
      if (it.action == ACT_UNUSED) return r;
      if (it.nbytes == 3'd0 || it.nbytes > 3'd4 || !it.clock_ok ||
          int'(it.offset) + int'(it.nbytes) > WINDOW_BYTES) return r;
      r.ok = 1'b1;

      // reads
      if (it.action == ACT_READ) begin
         if (it.offset == OFF_SEL && quad) begin
            r.read_data = window_shadow[W_SEL];
         end else if (mode == MODE_UART && it.offset == OFF_U_DATA && quad) begin
            if (it.uart_rx_avail) begin
               r.read_data = 32'(it.uart_rx_byte);
               r.uart_rx_pop = !it.peek;
            end
            if (!it.peek) window_shadow[W_ST][U_RDRF_BIT] = 1'b0;
         end else if (mode == MODE_SPI && it.offset == OFF_S_RDR && quad) begin
            if (shadow_held_valid) r.read_data = 32'(shadow_held_byte);
            if (!it.peek) begin
               shadow_held_valid = 1'b0;
               window_shadow[sr][S_RDF_BIT] = 1'b0;
            end
         end else if (mode != MODE_I2C) begin
            for (int i = 0; i < int'(it.nbytes); i++) begin
               a = it.offset + offset_type'(i);
               r.read_data[8*i +: 8] = window_shadow[word_of(a)][8*a[1:0] +: 8];
            end
         end
         return r;
      end

      // select word write, first entry into uart or spi sets up status
      if (it.offset == OFF_SEL && quad) begin
         next_mode = it.write_data[2:0];
         window_shadow[W_SEL] = it.write_data;
         if (mode != next_mode && !shadow_mode_started) begin
            if (next_mode == MODE_UART) begin
               window_shadow[W_ST] = U_STAT_START;
               shadow_mode_started = 1'b1;
            end else if (next_mode == MODE_SPI) begin
               window_shadow[sr] = S_SR_START;
               shadow_mode_started = 1'b1;
            end
         end
         return r;
      end

      if (mode == MODE_UART && it.offset == OFF_U_DATA && quad) begin
         if (window_shadow[W_CTRL][U_TE_BIT]) begin
            r.uart_tx_valid = 1'b1;
            r.uart_tx_byte  = it.write_data[7:0];
            window_shadow[W_ST] |= U_TX_DONE;
         end
      end else if (mode == MODE_SPI && it.offset == OFF_S_CR && quad) begin
         window_shadow[W_CR] = it.write_data;
         if (it.write_data[S_RRF_BIT]) begin
            shadow_held_valid = 1'b0;
            window_shadow[sr][S_RDF_BIT] = 1'b0;
         end
         r.spi_end = !it.write_data[S_MEN_BIT];
      end else if (mode == MODE_SPI && it.offset == OFF_S_TDR && quad) begin
         if (window_shadow[W_CR][S_MEN_BIT]) begin
            tcr = window_shadow[W_TCR];
            got = 8'hff;
            if (!tcr[S_TXMSK_BIT]) begin
               got = it.spi_in_byte;
               r.spi_xfer_valid = 1'b1;
               r.spi_out_byte   = it.write_data[7:0];
            end
            if (!tcr[S_RXMSK_BIT]) begin
               shadow_held_byte  = got;
               shadow_held_valid = 1'b1;
               window_shadow[sr][S_RDF_BIT] = 1'b1;
            end
            window_shadow[sr][S_TCF_BIT] = 1'b1;
            r.spi_end = !tcr[S_CONT_BIT];
         end
      end else begin
         for (int i = 0; i < int'(it.nbytes); i++) begin
            a = it.offset + offset_type'(i);
            window_shadow[word_of(a)][8*a[1:0] +: 8] = it.write_data[8*i +: 8];
         end
      end
      if (mode == MODE_SPI) refresh_spi_status();
      return r;
   endfunction

   // ------------------------------------------------------------------------
   // beat construction
   // ------------------------------------------------------------------------

   function automatic item_type make_item(logic [1:0] action, offset_type off,
                                          logic [2:0] size, logic [31:0] wd);
      item_type it;
      it            = '0;
      it.action     = action;
      it.offset     = off;
      it.nbytes     = size;
      it.write_data = wd;
      it.clock_ok   = 1'b1;
      return it;
   endfunction

   function automatic item_type select_item(logic [2:0] mode);
      logic [31:0] wd;
      wd      = $urandom;
      wd[2:0] = mode;
      return make_item(ACT_WRITE, OFF_SEL, 3'd4, wd);
   endfunction

   // mostly word accesses to the special registers, then unaligned
   // neighbors, the window end, random spots and malformed beats
   function automatic item_type random_access(logic [2:0] mode);
      item_type    it;
      int unsigned pick;
      offset_type  base;
      pick = $urandom_range(7);
      case (pick)
         0: base = OFF_S_CR;
         1: base = OFF_S_SR;
         2: base = OFF_U_CTRL;
         3: base = OFF_U_DATA;
         4: base = OFF_S_TCR;
         5: base = OFF_S_TDR;
         6: base = OFF_S_RDR;
         default: base = OFF_SEL;
      endcase
      it.action          = ($urandom_range(9) < 2) ? ACT_POLL :
                           ($urandom_range(1) == 0) ? ACT_READ : ACT_WRITE;
      it.offset          = base;
      it.nbytes          = 3'd4;
      it.write_data      = $urandom;
      it.clock_ok        = 1'b1;
      it.peek            = ($urandom_range(7) == 0);
      it.spi_in_byte     = 8'($urandom_range(255));
      it.uart_rx_avail   = 1'($urandom_range(1));
      it.uart_rx_byte    = 8'($urandom_range(255));
      it.uart_tx_empty   = 1'($urandom_range(1));
      it.uart_poll_event = ($urandom_range(3) != 0);
      pick = $urandom_range(99);
      if (pick >= 60 && pick < 78) begin
         it.offset = base - offset_type'(2) + offset_type'($urandom_range(4));
         it.nbytes = 3'($urandom_range(4, 1));
      end else if (pick >= 78 && pick < 84) begin
         it.offset = offset_type'(WINDOW_BYTES - $urandom_range(6, 1));
         it.nbytes = 3'($urandom_range(4, 1));
      end else if (pick >= 84 && pick < 92) begin
         it.offset = offset_type'($urandom_range(WINDOW_BYTES - 1));
         it.nbytes = 3'($urandom_range(4, 1));
      end else if (pick >= 92) begin
         it.action   = 2'($urandom_range(3));
         it.offset   = offset_type'($urandom_range(WINDOW_BYTES - 1));
         it.nbytes   = 3'($urandom_range(7));
         it.clock_ok = 1'($urandom_range(1));
      end
      // keep the session in its mode most of the time
      if (it.offset == OFF_SEL && it.nbytes == 3'd4 && $urandom_range(3) != 0)
         it.write_data[2:0] = mode;
      return it;
   endfunction

   // ------------------------------------------------------------------------
   // sender
   // ------------------------------------------------------------------------

   task automatic send_access(input item_type it);
      req_valid           <= 1'b1;
      req_action          <= it.action;
      req_offset          <= it.offset;
      req_nbytes          <= it.nbytes;
      req_write_data      <= it.write_data;
      req_clock_ok        <= it.clock_ok;
      req_peek            <= it.peek;
      req_spi_in_byte     <= it.spi_in_byte;
      req_uart_rx_avail   <= it.uart_rx_avail;
      req_uart_rx_byte    <= it.uart_rx_byte;
      req_uart_tx_empty   <= it.uart_tx_empty;
      req_uart_poll_event <= it.uart_poll_event;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      window_rsp_q.push_back(predict_window_access(it));
      accepted_items++;
      // random gaps after the beat
      if (!no_idle) begin
         while ($urandom_range(99) < 24) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
   endtask

   task automatic wait_all_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (window_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic run_sessions(input int unsigned count);
      int unsigned stop_at;
      int unsigned pick;
      logic [2:0]  mode;
      stop_at = accepted_items + count;
      while (accepted_items < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 35)      mode = MODE_UART;
         else if (pick < 70) mode = MODE_SPI;
         else if (pick < 80) mode = MODE_NONE;
         else if (pick < 90) mode = MODE_I2C;
         else                mode = MODE_SPARE_LO + 3'($urandom_range(3));
         send_access(select_item(mode));
         repeat ($urandom_range(30, 5))
            if (accepted_items < stop_at) send_access(random_access(mode));
      end
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // reset value of the select word, bounds, size and clock rejects
   task automatic test_window_checks();
      item_type it;
      send_access(make_item(ACT_READ, OFF_SEL, 3'd4, '0));
      it = make_item(ACT_WRITE, '0, 3'd1, 32'hffff_ffff);
      it.peek = 1'b1;
      send_access(it);
      send_access(make_item(ACT_READ, 12'hfff, 3'd1, '0));
      send_access(make_item(ACT_WRITE, 12'hfff, 3'd2, 32'hffff_ffff));
      send_access(make_item(ACT_READ, '0, 3'd0, '0));
      send_access(make_item(ACT_READ, '0, 3'd7, '0));
      it = make_item(ACT_READ, '0, 3'd1, '0);
      it.clock_ok = 1'b0;
      send_access(it);
      send_access(make_item(ACT_UNUSED, '0, 3'd4, 32'hffff_ffff));
      send_access(make_item(ACT_POLL, '0, 3'd0, '0));
   endtask

   // uart entry, transmit, poll, peek and popping receive read
   task automatic test_uart_path();
      item_type it;
      send_access(make_item(ACT_WRITE, OFF_SEL, 3'd4, 32'(MODE_UART)));
      send_access(make_item(ACT_WRITE, OFF_U_CTRL, 3'd4, 32'h1 << U_TE_BIT));
      send_access(make_item(ACT_WRITE, OFF_U_DATA, 3'd4, 32'h0000_00a5));
      it = make_item(ACT_POLL, '0, 3'd4, '0);
      it.uart_poll_event = 1'b1;
      it.uart_tx_empty   = 1'b1;
      it.uart_rx_avail   = 1'b1;
      send_access(it);
      it = make_item(ACT_READ, OFF_U_DATA, 3'd4, '0);
      it.uart_rx_avail = 1'b1;
      it.uart_rx_byte  = 8'hff;
      it.peek          = 1'b1;
      send_access(it);
      it.peek = 1'b0;
      send_access(it);
      send_access(make_item(ACT_READ, OFF_U_STAT, 3'd4, '0));
   endtask

   // spi exchange, receive holding byte, masks, continuous and idle end
   task automatic test_spi_path();
      item_type it;
      send_access(make_item(ACT_WRITE, OFF_SEL, 3'd4, 32'(MODE_SPI)));
      send_access(make_item(ACT_WRITE, OFF_S_CR, 3'd4,
                            (32'h1 << S_MEN_BIT) | (32'h1 << S_RRF_BIT)));
      it = make_item(ACT_WRITE, OFF_S_TDR, 3'd4, 32'h0000_005a);
      it.spi_in_byte = 8'hc3;
      send_access(it);
      send_access(make_item(ACT_READ, OFF_S_RDR, 3'd4, '0));
      send_access(make_item(ACT_WRITE, OFF_S_TCR, 3'd4,
                            (32'h1 << S_TXMSK_BIT) | (32'h1 << S_CONT_BIT)));
      send_access(it);
      send_access(make_item(ACT_WRITE, OFF_S_CR, 3'd4, '0));
   endtask

   // i2c reads as zero, spare select codes act as plain storage
   task automatic test_other_modes();
      send_access(make_item(ACT_WRITE, OFF_SEL, 3'd4, 32'(MODE_I2C)));
      send_access(make_item(ACT_READ, OFF_S_CR, 3'd4, '0));
      send_access(make_item(ACT_WRITE, OFF_SEL, 3'd4, 32'(MODE_SPARE_LO) | 32'hffff_fff8));
      send_access(make_item(ACT_READ, OFF_S_CR, 3'd4, '0));
   endtask

   // receiver holds off while the sender keeps offering beats
   task automatic test_backpressure();
      hold_off_req = 1'b1;
      run_sessions(80);
   endtask

   // sender stops until every response is back
   task automatic test_drain_pause();
      wait_all_responses();
   endtask

   // back to back beats with both sides always ready
   task automatic test_streaming();
      no_idle = 1'b1;
      run_sessions(200);
      no_idle = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // receiver
   // ------------------------------------------------------------------------

   initial begin
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= no_idle || ($urandom_range(99) >= 24);
      end
   end

   // ------------------------------------------------------------------------
   // response checking
   // ------------------------------------------------------------------------

   task automatic report_mismatch(input string what);
      $display("mismatch: %s", what);
      mismatch_count++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("beat %0d %s got %h want %h", rsp_count, name, got, want));
   endtask

   always @(posedge clock) begin : rsp_checker
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_count++;
         if (window_rsp_q.size() == 0) begin
            report_mismatch($sformatf("beat %0d arrived with nothing pending", rsp_count));
         end else begin
            want = window_rsp_q.pop_front();
            check_field("ok", 32'(rsp_ok), 32'(want.ok));
            check_field("read_data", rsp_read_data, want.read_data);
            check_field("uart_rx_pop", 32'(rsp_uart_rx_pop), 32'(want.uart_rx_pop));
            check_field("uart_tx_valid", 32'(rsp_uart_tx_valid), 32'(want.uart_tx_valid));
            check_field("uart_tx_byte", 32'(rsp_uart_tx_byte), 32'(want.uart_tx_byte));
            check_field("spi_xfer_valid", 32'(rsp_spi_xfer_valid), 32'(want.spi_xfer_valid));
            check_field("spi_out_byte", 32'(rsp_spi_out_byte), 32'(want.spi_out_byte));
            check_field("spi_end", 32'(rsp_spi_end), 32'(want.spi_end));
         end
      end
   end

   // no beat moving on either side for too long
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // test sequence
   // ------------------------------------------------------------------------

   initial begin
      clear_shadow();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_window_checks();
      test_uart_path();
      test_spi_path();
      test_other_modes();
      run_sessions(500);
      test_backpressure();
      test_drain_pause();
      test_streaming();
      run_sessions(550);
      wait_all_responses();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && window_rsp_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
`default_nettype wire

// File: files.f
rtl/srb_pkg.sv
rtl/srb_bank.sv
rtl/srb_core.sv
rtl/multiprotocol_serial_register_block.sv
tb/multiprotocol_serial_register_block_tb.sv
